@@ hdl/pointer_motion_accumulator_unit_macros.svh @@
// pointer_motion_accumulator_unit_macros.svh
// assertion macros for the pointer motion accumulator checker
// expects signals named clock and reset in the scope of each use
`ifndef POINTER_MOTION_ACCUMULATOR_UNIT_MACROS_SVH
`define POINTER_MOTION_ACCUMULATOR_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PMA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define PMA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pma_pkg.sv @@
// pma_pkg.sv
// shared types, register map and constants of the pointer motion accumulator
// no dependencies
`timescale 1ns / 1ps

package pma_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int DIV_W      = 32;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam logic [15:0] RST_SCREEN_WIDTH  = 16'd80;
   localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd25;
   localparam logic [31:0] RST_POINTER_GAIN  = 32'd300000;
   localparam logic [15:0] RST_FIRST_CODE    = 16'd1;
   localparam logic [15:0] RST_SECOND_CODE   = 16'd2;
   localparam logic [15:0] RST_THIRD_CODE    = 16'd4;

   typedef enum logic [2:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_POINTER_GAIN  = 3'd2,
      REG_FIRST_CODE    = 3'd3,
      REG_SECOND_CODE   = 3'd4,
      REG_THIRD_CODE    = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      EV_MOVE = 2'd0,
      EV_DOWN = 2'd1,
      EV_UP   = 2'd2
   } event_kind_type;

   localparam logic [1:0] BTN_NONE   = 2'd0;
   localparam logic [1:0] BTN_FIRST  = 2'd1;
   localparam logic [1:0] BTN_SECOND = 2'd2;
   localparam logic [1:0] BTN_THIRD  = 2'd3;

   typedef struct packed {
      logic [15:0] screen_width;
      logic [15:0] screen_height;
      logic [31:0] pointer_gain;
      logic [15:0] first_code;
      logic [15:0] second_code;
      logic [15:0] third_code;
      logic        size_written;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // number of significant bits of a motion magnitude
   function automatic logic [4:0] bit_length(input logic [16:0] mag);
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < 17; i++) begin
         if (mag[i]) n = 5'(i + 1);
      end
      return n;
   endfunction

endpackage

@@ hdl/pma_channels.sv @@
// pma_channels.sv
// valid/ready channel interfaces for packets in and events out
// no dependencies
`timescale 1ns / 1ps

interface pma_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] motion_x;
   logic signed [15:0] motion_y;
   logic        [15:0] button_flags;

   modport source (output valid, output motion_x, output motion_y, output button_flags,
                   input ready);
   modport sink (input valid, input motion_x, input motion_y, input button_flags,
                 output ready);
endinterface

interface pma_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [15:0] cell_x;
   logic [15:0] cell_y;
   logic [1:0]  button_number;
   logic        last_event;

   modport source (output valid, output event_kind, output cell_x, output cell_y,
                   output button_number, output last_event, input ready);
   modport sink (input valid, input event_kind, input cell_x, input cell_y,
                 input button_number, input last_event, output ready);
endinterface

@@ hdl/pointer_motion_accumulator_unit.sv @@
// channel   dir  handshake      payload
// req_chan  in   valid/ready    motion_x, motion_y, button_flags
// rsp_chan  out  valid/ready    event_kind, cell_x, cell_y, button_number, last_event
// apb       in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// one packet at a time: the two axes in turn on the shared multiplier, then
// two divisions for the cells on the serial divider, and two more for the
// scale factors after reset or a screen size write.
// req ready is high only when no packet is in work and no event waits
// a stalled event holds in the output register until taken
// reset is synchronous; positions and previous flags clear to zero
`timescale 1ns / 1ps

module pointer_motion_accumulator_unit (
   input  logic                            clock,
   input  logic                            reset,
   pma_req_if.sink                         req_chan,
   pma_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pma_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import pma_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_MUL_A    = 8'b0000_0010,
      ST_MUL_B    = 8'b0000_0100,
      ST_ADD      = 8'b0000_1000,
      ST_DIV_GO   = 8'b0001_0000,
      ST_DIV_WAIT = 8'b0010_0000,
      ST_EMIT     = 8'b0100_0000,
      ST_OUT      = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      DS_SCALE_X = 2'd0,
      DS_SCALE_Y = 2'd1,
      DS_CELL_X  = 2'd2,
      DS_CELL_Y  = 2'd3
   } div_sel_type;

   cfg_type      cfg;
   div_stat_type div_stat;

   state_type          state_ff, state_in;
   div_sel_type        div_sel_ff, div_sel_in;
   logic               axis_ff, axis_in;
   logic               scale_ok_ff, scale_ok_in;
   logic               pending_ff, pending_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        prev_flags_ff, prev_flags_in;
   logic [31:0]        pos_x_ff, pos_x_in;
   logic [31:0]        pos_y_ff, pos_y_in;

   logic signed [16:0] mx_ff, mx_in;
   logic signed [16:0] my_ff, my_in;
   logic               move_ff, move_in;
   event_kind_type     kind_ff, kind_in;
   logic [1:0]         btn_ff, btn_in;
   logic [31:0]        scale_x_ff, scale_x_in;
   logic [31:0]        scale_y_ff, scale_y_in;
   logic [15:0]        cell_x_ff, cell_x_in;
   logic [15:0]        cell_y_ff, cell_y_in;
   event_kind_type     out_kind_ff, out_kind_in;
   logic [1:0]         out_btn_ff, out_btn_in;
   logic               out_last_ff, out_last_in;

   // operand and result signals of the shared units
   logic signed [16:0] motion_cur;
   logic        [16:0] mag;
   logic        [4:0]  bit_len;
   logic signed [20:0] mul_a;
   logic        [31:0] mul_b;
   logic signed [53:0] mul_prod;
   logic        [31:0] pos_cur;
   logic signed [54:0] sum;
   logic        [31:0] sat_pos;
   logic               div_start;
   logic        [31:0] div_dividend, div_divisor, div_quotient;
   logic        [15:0] width_m1, height_m1;

   // button decode of the incoming beat
   logic [15:0]        flags;
   logic               flags_down;
   logic [15:0]        diff;
   logic [1:0]         btn_match;

   pma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pma_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   pma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // axis datapath around the multiplier
   assign motion_cur = axis_ff ? my_ff : mx_ff;
   assign mag        = motion_cur[16] ? 17'(-motion_cur) : 17'(motion_cur);
   assign bit_len    = bit_length(mag);
   assign mul_a      = (state_ff == ST_MUL_B) ? $signed(mul_prod[20:0]) : 21'(motion_cur);
   assign mul_b      = (state_ff == ST_MUL_B) ? cfg.pointer_gain : 32'(bit_len);

   assign pos_cur = axis_ff ? pos_y_ff : pos_x_ff;
   assign sum     = $signed({23'd0, pos_cur}) + 55'(mul_prod);
   always_comb begin
      if (sum[54]) begin
         sat_pos = '0;
      end else if (|sum[53:32]) begin
         sat_pos = ALL_ONES;
      end else begin
         sat_pos = sum[31:0];
      end
   end

   // sizes below two count as two
   assign width_m1  = (cfg.screen_width < 16'd2) ? 16'd1 : cfg.screen_width - 16'd1;
   assign height_m1 = (cfg.screen_height < 16'd2) ? 16'd1 : cfg.screen_height - 16'd1;

   always_comb begin
      case (div_sel_ff)
         DS_SCALE_X: begin
            div_dividend = ALL_ONES;
            div_divisor  = 32'(width_m1);
         end
         DS_SCALE_Y: begin
            div_dividend = ALL_ONES;
            div_divisor  = 32'(height_m1);
         end
         DS_CELL_X: begin
            div_dividend = pos_x_ff;
            div_divisor  = scale_x_ff;
         end
         DS_CELL_Y: begin
            div_dividend = pos_y_ff;
            div_divisor  = scale_y_ff;
         end
         default: begin
            div_dividend = ALL_ONES;
            div_divisor  = 32'(width_m1);
         end
      endcase
   end

   // flag difference against the previous packet, later codes win
   assign flags      = req_chan.button_flags;
   assign flags_down = flags > prev_flags_ff;
   assign diff       = flags_down ? flags - prev_flags_ff : prev_flags_ff - flags;
   always_comb begin
      btn_match = BTN_NONE;
      if (diff == cfg.first_code)  btn_match = BTN_FIRST;
      if (diff == cfg.second_code) btn_match = BTN_SECOND;
      if (diff == cfg.third_code)  btn_match = BTN_THIRD;
   end

   always_comb begin
      state_in      = state_ff;
      div_sel_in    = div_sel_ff;
      axis_in       = axis_ff;
      scale_ok_in   = scale_ok_ff;
      pending_in    = pending_ff;
      rsp_valid_in  = rsp_valid_ff;
      prev_flags_in = prev_flags_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      move_in       = move_ff;
      kind_in       = kind_ff;
      btn_in        = btn_ff;
      scale_x_in    = scale_x_ff;
      scale_y_in    = scale_y_ff;
      cell_x_in     = cell_x_ff;
      cell_y_in     = cell_y_ff;
      out_kind_in   = out_kind_ff;
      out_btn_in    = out_btn_ff;
      out_last_in   = out_last_ff;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               mx_in         = 17'(req_chan.motion_x);
               my_in         = -(17'(req_chan.motion_y));
               move_in       = (req_chan.motion_x != '0) || (req_chan.motion_y != '0);
               kind_in       = flags_down ? EV_DOWN : EV_UP;
               btn_in        = (flags != prev_flags_ff) ? btn_match : BTN_NONE;
               prev_flags_in = flags;
               axis_in       = 1'b0;
               state_in      = ST_MUL_A;
            end
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_ADD;
         ST_ADD: begin
            if (!axis_ff) begin
               pos_x_in = sat_pos;
               axis_in  = 1'b1;
               state_in = ST_MUL_A;
            end else begin
               pos_y_in   = sat_pos;
               div_sel_in = scale_ok_ff ? DS_CELL_X : DS_SCALE_X;
               state_in   = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_DIV_GO;
               case (div_sel_ff)
                  DS_SCALE_X: begin
                     scale_x_in = div_quotient;
                     div_sel_in = DS_SCALE_Y;
                  end
                  DS_SCALE_Y: begin
                     scale_y_in  = div_quotient;
                     scale_ok_in = 1'b1;
                     div_sel_in  = DS_CELL_X;
                  end
                  DS_CELL_X: begin
                     cell_x_in  = div_quotient[15:0];
                     div_sel_in = DS_CELL_Y;
                  end
                  DS_CELL_Y: begin
                     cell_y_in = div_quotient[15:0];
                     state_in  = ST_EMIT;
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_EMIT: begin
            if (move_ff) begin
               out_kind_in  = EV_MOVE;
               out_btn_in   = BTN_NONE;
               pending_in   = (btn_ff != BTN_NONE);
               out_last_in  = (btn_ff == BTN_NONE);
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end else if (btn_ff != BTN_NONE) begin
               out_kind_in  = kind_ff;
               out_btn_in   = btn_ff;
               pending_in   = 1'b0;
               out_last_in  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               if (pending_ff) begin
                  // button beat follows the move beat of the same packet
                  out_kind_in = kind_ff;
                  out_btn_in  = btn_ff;
                  out_last_in = 1'b1;
                  pending_in  = 1'b0;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cfg.size_written) scale_ok_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         div_sel_ff    <= DS_SCALE_X;
         axis_ff       <= 1'b0;
         scale_ok_ff   <= 1'b0;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_flags_ff <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         div_sel_ff    <= div_sel_in;
         axis_ff       <= axis_in;
         scale_ok_ff   <= scale_ok_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_flags_ff <= prev_flags_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
      end
   end

   always_ff @(posedge clock) begin
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      move_ff     <= move_in;
      kind_ff     <= kind_in;
      btn_ff      <= btn_in;
      scale_x_ff  <= scale_x_in;
      scale_y_ff  <= scale_y_in;
      cell_x_ff   <= cell_x_in;
      cell_y_ff   <= cell_y_in;
      out_kind_ff <= out_kind_in;
      out_btn_ff  <= out_btn_in;
      out_last_ff <= out_last_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.event_kind    = out_kind_ff;
   assign rsp_chan.cell_x        = cell_x_ff;
   assign rsp_chan.cell_y        = cell_y_ff;
   assign rsp_chan.button_number = out_btn_ff;
   assign rsp_chan.last_event    = out_last_ff;

endmodule

@@ hdl/pma_csr.sv @@
// pma_csr.sv
// apb register file: screen size, gain and button codes
// depends on pma_pkg
`timescale 1ns / 1ps

module pma_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pma_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output pma_pkg::cfg_type                  cfg
);
   import pma_pkg::*;

   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] gain_ff, gain_in;
   logic [15:0] code1_ff, code1_in;
   logic [15:0] code2_ff, code2_in;
   logic [15:0] code3_ff, code3_in;
   logic        size_wr_ff, size_wr_in;
   logic        wr_en;
   logic [2:0]  index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = paddr[4:2];

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      gain_in    = gain_ff;
      code1_in   = code1_ff;
      code2_in   = code2_ff;
      code3_in   = code3_ff;
      size_wr_in = 1'b0;
      if (wr_en) begin
         case (index)
            REG_SCREEN_WIDTH: begin
               width_in   = pwdata[15:0];
               size_wr_in = 1'b1;
            end
            REG_SCREEN_HEIGHT: begin
               height_in  = pwdata[15:0];
               size_wr_in = 1'b1;
            end
            REG_POINTER_GAIN: gain_in  = pwdata;
            REG_FIRST_CODE:   code1_in = pwdata[15:0];
            REG_SECOND_CODE:  code2_in = pwdata[15:0];
            REG_THIRD_CODE:   code3_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RST_SCREEN_WIDTH;
         height_ff  <= RST_SCREEN_HEIGHT;
         gain_ff    <= RST_POINTER_GAIN;
         code1_ff   <= RST_FIRST_CODE;
         code2_ff   <= RST_SECOND_CODE;
         code3_ff   <= RST_THIRD_CODE;
         size_wr_ff <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         gain_ff    <= gain_in;
         code1_ff   <= code1_in;
         code2_ff   <= code2_in;
         code3_ff   <= code3_in;
         size_wr_ff <= size_wr_in;
      end
   end

   always_comb begin
      case (index)
         REG_SCREEN_WIDTH:  prdata = {16'd0, width_ff};
         REG_SCREEN_HEIGHT: prdata = {16'd0, height_ff};
         REG_POINTER_GAIN:  prdata = gain_ff;
         REG_FIRST_CODE:    prdata = {16'd0, code1_ff};
         REG_SECOND_CODE:   prdata = {16'd0, code2_ff};
         REG_THIRD_CODE:    prdata = {16'd0, code3_ff};
         default:           prdata = '0;
      endcase
   end

   assign cfg.screen_width  = width_ff;
   assign cfg.screen_height = height_ff;
   assign cfg.pointer_gain  = gain_ff;
   assign cfg.first_code    = code1_ff;
   assign cfg.second_code   = code2_ff;
   assign cfg.third_code    = code3_ff;
   assign cfg.size_written  = size_wr_ff;

endmodule

@@ hdl/pma_mul.sv @@
// pma_mul.sv
// shared registered multiplier: signed 21-bit by unsigned 32-bit
// no dependencies
`timescale 1ns / 1ps

module pma_mul (
   input  logic               clock,
   input  logic signed [20:0] op_a,
   input  logic        [31:0] op_b,
   output logic signed [53:0] prod
);
   logic signed [53:0] prod_ff, prod_in;

   assign prod_in = op_a * $signed({1'b0, op_b});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hdl/pma_div.sv @@
// pma_div.sv
// restoring divider, one quotient bit per cycle
// depends on pma_pkg
`timescale 1ns / 1ps

module pma_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pma_pkg::DIV_W-1:0]    dividend,
   input  logic [pma_pkg::DIV_W-1:0]    divisor,
   output logic [pma_pkg::DIV_W-1:0]    quotient,
   output pma_pkg::div_stat_type        stat
);
   import pma_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W+1:0] trial;

   assign trial = {1'b0, rem_ff, quo_ff[DIV_W-1]} - {2'b00, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIV_W);
         rem_in   = '0;
         quo_in   = dividend;
         den_in   = divisor;
      end else if (busy_ff) begin
         if (!trial[DIV_W+1]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ hdl/pma_checker.sv @@
// pma_checker.sv
// port-level assertions for pointer_motion_accumulator_unit, bound to the top
// depends on pma_pkg and pointer_motion_accumulator_unit_macros.svh
`timescale 1ns / 1ps
`include "pointer_motion_accumulator_unit_macros.svh"

module pma_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_kind,
   input logic [15:0] rsp_cell_x,
   input logic [15:0] rsp_cell_y,
   input logic [1:0]  rsp_button_number,
   input logic        rsp_last_event
);
   import pma_pkg::*;

   // no new packet while an event of the last one is still offered
   `PMA_ASSERT_NOW(a_busy_while_rsp, rsp_valid, !req_ready, "req ready while event pending")

   // a packet in work blocks the input
   `PMA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready,
                    "req ready right after a beat")

   // stalled event beat holds
   `PMA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable({rsp_event_kind, rsp_cell_x, rsp_cell_y,
                                          rsp_button_number, rsp_last_event}),
                    "stalled event beat changed")

   // move beats carry no button, button beats carry one
   `PMA_ASSERT_NOW(a_kind_button, rsp_valid,
                   (rsp_event_kind == EV_MOVE && rsp_button_number == BTN_NONE) ||
                   ((rsp_event_kind == EV_DOWN || rsp_event_kind == EV_UP) &&
                    rsp_button_number != BTN_NONE),
                   "event kind and button number disagree")

   // a beat not marked last is followed at once by the button beat
   `PMA_ASSERT_NEXT(a_second_beat, rsp_valid && rsp_ready && !rsp_last_event,
                    rsp_valid && rsp_event_kind != EV_MOVE,
                    "missing button beat after move beat")

endmodule

bind pointer_motion_accumulator_unit pma_checker u_pma_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_event_kind    (rsp_chan.event_kind),
   .rsp_cell_x        (rsp_chan.cell_x),
   .rsp_cell_y        (rsp_chan.cell_y),
   .rsp_button_number (rsp_chan.button_number),
   .rsp_last_event    (rsp_chan.last_event)
);
